// ----- rtl/sve_pkg.sv -----
// Package of the vertical Sobel edge filter: widths, register codes, the
// status word passed from the frame counters to the datapath, and the
// register clamp. Used by every module of the block but the RAM; depends on nothing.
package sve_pkg;

    localparam int MAX_LINE_PIXELS = 512;
    localparam int MAX_FRAME_ROWS  = 512;

    localparam int PIX_W = 8;
    localparam int DIM_W = 10;
    localparam int COL_W = $clog2(MAX_LINE_PIXELS);
    localparam int ROW_W = $clog2(MAX_FRAME_ROWS);
    localparam int CMP_W = ((COL_W > DIM_W) ? COL_W : DIM_W) + 1;
    localparam int ROWCMP_W = ((ROW_W > DIM_W) ? ROW_W : DIM_W) + 1;

    localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};

    localparam int CFG_ADDR_W = 1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } sve_reg_t;

    // Flags for one input item, worked out from the frame counters.
    typedef struct packed {
        logic due;     // the item produces a result
        logic border;  // the result lies on the image border
        logic last;    // the result is the last of the frame
    } sve_pos_t;

    // Zero becomes one; anything above the top saturates to it.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] value,
                                                   input logic [DIM_W:0] top);
        logic [DIM_W:0] v;
        begin
            v = {1'b0, value};
            if (v == '0) begin
                v = {{DIM_W{1'b0}}, 1'b1};
            end
            if (v > top) begin
                v = top;
            end
            clamp_dim = v[DIM_W-1:0];
        end
    endfunction

endpackage

// ----- rtl/sve_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands on its own; no package needed.
module sve_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/sve_ctrl.sv -----
// Frame geometry registers and the input and output position counters.
// Depends on sve_pkg.
module sve_ctrl
    import sve_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [DIM_W-1:0]       cfg_wdata,
    input  logic                   accept,
    output logic [COL_W-1:0]       slot,
    output sve_pos_t               pos
);

    logic [DIM_W-1:0] width_reg,   width_next;
    logic [DIM_W-1:0] height_reg,  height_next;
    logic [COL_W-1:0] in_col_reg,  in_col_next;
    logic [1:0]       in_row_reg,  in_row_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    logic             started_reg, started_next;

    logic in_wrap, col_end, row_end;

    assign in_wrap = (CMP_W'(in_col_reg) + CMP_W'(1)) >= CMP_W'(width_reg);
    assign col_end = (CMP_W'(out_col_reg) + CMP_W'(1)) >= CMP_W'(width_reg);
    assign row_end = (ROWCMP_W'(out_row_reg) + ROWCMP_W'(1)) >= ROWCMP_W'(height_reg);

    always_comb begin
        pos.due    = started_reg || (in_row_reg == 2'd2)
                     || ((in_row_reg == 2'd1) && (in_col_reg != '0));
        pos.border = (out_row_reg == '0) || row_end || (out_col_reg == '0) || col_end;
        pos.last   = row_end && col_end;
    end

    assign slot = in_col_reg;

    always_comb begin
        width_next   = width_reg;
        height_next  = height_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        started_next = started_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                REG_FRAME_WIDTH: begin
                    width_next = clamp_dim(cfg_wdata, (DIM_W+1)'(MAX_LINE_PIXELS));
                end
                REG_FRAME_HEIGHT: begin
                    height_next = clamp_dim(cfg_wdata, (DIM_W+1)'(MAX_FRAME_ROWS));
                end
                default: begin
                end
            endcase
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
            started_next = 1'b0;
        end else if (accept) begin
            if (in_wrap) begin
                in_col_next = '0;
                if (in_row_reg != 2'd2) begin
                    in_row_next = in_row_reg + 2'd1;
                end
            end else begin
                in_col_next = in_col_reg + COL_W'(1);
            end
            if (pos.due) begin
                started_next = 1'b1;
                if (pos.last) begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                    started_next = 1'b0;
                end else if (col_end) begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + ROW_W'(1);
                end else begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= DIM_W'(MAX_LINE_PIXELS);
            height_reg  <= DIM_W'(MAX_FRAME_ROWS);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            started_reg <= 1'b0;
        end else begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            started_reg <= started_next;
        end
    end

endmodule

// ----- rtl/sve_window.sv -----
// Upper and lower rows of the 3x3 window and the clamped vertical gradient.
// Depends on sve_pkg.
module sve_window
    import sve_pkg::*;
(
    input  logic             aclk,
    input  logic             shift_en,
    input  logic [PIX_W-1:0] col_up,
    input  logic [PIX_W-1:0] col_down,
    output logic [PIX_W-1:0] grad
);

    // Index 2 is the newest column. The middle row never enters the sum.
    logic [PIX_W-1:0] up_reg   [3];
    logic [PIX_W-1:0] down_reg [3];

    logic [PIX_W+1:0] above, below;
    logic [PIX_W+2:0] diff;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            up_reg[0]   <= up_reg[1];
            up_reg[1]   <= up_reg[2];
            up_reg[2]   <= col_up;
            down_reg[0] <= down_reg[1];
            down_reg[1] <= down_reg[2];
            down_reg[2] <= col_down;
        end
    end

    always_comb begin
        above = (PIX_W+2)'(up_reg[0]) + {1'b0, up_reg[1], 1'b0} + (PIX_W+2)'(up_reg[2]);
        below = (PIX_W+2)'(down_reg[0]) + {1'b0, down_reg[1], 1'b0}
                + (PIX_W+2)'(down_reg[2]);
        diff  = (PIX_W+3)'(below) - (PIX_W+3)'(above);
        if (diff[PIX_W+2]) begin
            grad = '0;
        end else if (diff[PIX_W+1:PIX_W] != 2'b00) begin
            grad = PIX_MAX;
        end else begin
            grad = diff[PIX_W-1:0];
        end
    end

endmodule

// ----- rtl/sobel_vertical_edge_3x3.sv -----
// Vertical Sobel edge filter, 3x3 window over a raster stream of grey pixels.
// Throughput: one item per clock while m_tready is high; each item passes
// through the line store read stage and then the window stage.
// A result enters the output register from the window stage, after the item
// that completes its window, frame_width + 1 places later, has passed stage A.
// Reset (aresetn, synchronous, low) empties the pipeline, zeroes the counters
// and sets both frame dimensions to 512; the line stores are not cleared.
module sobel_vertical_edge_3x3
    import sve_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [DIM_W-1:0]      cfg_wdata,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] pixel
    input  logic                  s_tuser,   // [0] cmd: flush item when set

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [7:0] edge_value
    output logic                  m_tlast    // frame_last
);

    // The pipeline has three stages. Stage A holds the accepted pixel while
    // the line store returns the two older pixels of its column. Stage B owns
    // the window after the shift. The output register holds one result.
    // Each stage moves on as soon as the one after it has room, so a result
    // waiting at the output does not stop items filling the earlier stages.

    logic                  accept;
    logic [COL_W-1:0]      slot;
    sve_pos_t              pos;

    logic                  a_valid_reg, a_valid_next;
    logic [PIX_W-1:0]      a_pix_reg;
    logic [COL_W-1:0]      a_slot_reg;
    sve_pos_t              a_pos_reg;

    logic                  b_valid_reg, b_valid_next;
    sve_pos_t              b_pos_reg;

    logic                  m_valid_reg, m_valid_next;
    logic [PIX_W-1:0]      m_edge_reg;
    logic                  m_last_reg;

    logic                  out_ready, b_adv, b_ready, a_adv, a_ready;
    logic [2*PIX_W-1:0]    store_rdata;
    logic [PIX_W-1:0]      older_pix, newer_pix;
    logic [PIX_W-1:0]      grad;

    // Handshake chain, from the result side back to the input. No item is
    // taken while reset is held.
    assign out_ready = !m_valid_reg || m_tready;
    assign b_adv     = b_valid_reg && (!b_pos_reg.due || out_ready);
    assign b_ready   = !b_valid_reg || b_adv;
    assign a_adv     = a_valid_reg && b_ready;
    assign a_ready   = !a_valid_reg || a_adv;
    assign s_tready  = a_ready && aresetn;
    assign accept    = s_tvalid && s_tready;

    sve_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .slot      (slot),
        .pos       (pos)
    );

    // Both line stores share one RAM word: the older row in the upper byte,
    // the newer row in the lower. The read is issued as the item is accepted
    // and the word held while stage A waits; the write-back happens as the
    // item leaves stage A. A one-pixel-wide frame can read a column in the
    // same cycle as it is written back, and every result of such a frame is
    // zero whatever the window holds.
    assign older_pix = store_rdata[2*PIX_W-1:PIX_W];
    assign newer_pix = store_rdata[PIX_W-1:0];

    sve_ram #(
        .WIDTH (2*PIX_W),
        .DEPTH (MAX_LINE_PIXELS)
    ) u_line_store (
        .aclk  (aclk),
        .we    (a_adv),
        .waddr (a_slot_reg),
        .wdata ({newer_pix, a_pix_reg}),
        .re    (accept),
        .raddr (slot),
        .rdata (store_rdata)
    );

    sve_window u_window (
        .aclk     (aclk),
        .shift_en (a_adv),
        .col_up   (older_pix),
        .col_down (a_pix_reg),
        .grad     (grad)
    );

    always_comb begin
        a_valid_next = a_valid_reg;
        if (accept) begin
            a_valid_next = 1'b1;
        end else if (a_adv) begin
            a_valid_next = 1'b0;
        end

        b_valid_next = b_valid_reg;
        if (a_adv) begin
            b_valid_next = 1'b1;
        end else if (b_adv) begin
            b_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (b_adv && b_pos_reg.due) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers. A flush item enters the window as a zero pixel.
    always_ff @(posedge aclk) begin
        if (accept) begin
            a_pix_reg  <= s_tuser ? '0 : s_tdata[PIX_W-1:0];
            a_slot_reg <= slot;
            a_pos_reg  <= pos;
        end
        if (a_adv) begin
            b_pos_reg <= a_pos_reg;
        end
        if (b_adv && b_pos_reg.due) begin
            m_edge_reg <= b_pos_reg.border ? '0 : grad;
            m_last_reg <= b_pos_reg.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = 8'(m_edge_reg);
    assign m_tlast  = m_last_reg;

endmodule

// ----- rtl/sve_checker.sv -----
// Port-level checks for sobel_vertical_edge_3x3, bound to the top level.
// Depends on sve_pkg for widths.
module sve_checker
    import sve_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [PIX_W-1:0]      m_tdata,
    input logic                  m_tlast
);

    // A held result keeps its payload until taken.
    a_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // With the output register empty, every stage behind it has room.
    a_ready_when_empty : assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output register");

    // The last pixel of a frame is a corner and so on the border.
    a_last_is_border : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata == '0)
        else $error("frame end result is not zero");

    // Nothing comes out in the cycle after reset.
    a_reset_empty : assert property (@(posedge aclk)
        aresetn && $past(!aresetn) |-> !m_tvalid)
        else $error("result present straight after reset");

endmodule

bind sobel_vertical_edge_3x3 sve_checker u_sve_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ----- tb/sobel_vertical_edge_3x3_checker.sv -----
// Scoreboard for the vertical Sobel edge filter: watches the register port and
// both stream channels, predicts every edge value and compares in order.
// Depends on sve_pkg for widths, register codes and the line store depth.
module sobel_vertical_edge_3x3_checker
    import sve_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [DIM_W-1:0]      cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [7:0]            m_tdata,
    input  logic                  m_tlast,
    output int                    fail_count,
    output int                    pending_edges,
    output int                    edges_checked,
    output int                    edges_nonzero
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_CAP = 40;
    localparam int ROW_CAP    = 'hFFFF;

    typedef struct packed {
        logic [PIX_W-1:0] edge_value;
        logic             frame_last;
    } edge_result_t;

    logic [PIX_W-1:0] older_row [MAX_LINE_PIXELS];
    logic [PIX_W-1:0] newer_row [MAX_LINE_PIXELS];
    logic [PIX_W-1:0] window [3][3];

    int unsigned  width_px;
    int unsigned  height_rows;
    int unsigned  in_col;
    int unsigned  in_row;
    int unsigned  out_col;
    int unsigned  out_row;
    bit           out_started;
    edge_result_t awaited_edges [$];

    int mismatches;
    int checked;
    int nonzero;

    assign fail_count    = mismatches;
    assign edges_checked = checked;
    assign edges_nonzero = nonzero;

    initial begin
        mismatches = 0;
        checked    = 0;
        nonzero    = 0;
    end

    function automatic void restart_frame();
        in_col      = 0;
        in_row      = 0;
        out_col     = 0;
        out_row     = 0;
        out_started = 1'b0;
    endfunction

    function automatic void reset_model();
        width_px    = MAX_LINE_PIXELS;
        height_rows = MAX_FRAME_ROWS;
        for (int i = 0; i < MAX_LINE_PIXELS; i++) begin
            older_row[i] = '0;
            newer_row[i] = '0;
        end
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                window[r][c] = '0;
            end
        end
        restart_frame();
    endfunction

    // Zero is taken as one, anything beyond the given top as that top.
    function automatic int unsigned limit_dim(input logic [DIM_W-1:0] value,
                                              input int unsigned top);
        int unsigned v;
        v = value;
        if (v == 0) begin
            v = 1;
        end
        if (v > top) begin
            v = top;
        end
        return v;
    endfunction

    function automatic void apply_setting(input logic [CFG_ADDR_W-1:0] addr,
                                          input logic [DIM_W-1:0] value);
        case (sve_reg_t'(addr))
            REG_FRAME_WIDTH: begin
                width_px = limit_dim(value, MAX_LINE_PIXELS);
                restart_frame();
            end
            REG_FRAME_HEIGHT: begin
                height_rows = limit_dim(value, MAX_FRAME_ROWS);
                restart_frame();
            end
            default: begin
            end
        endcase
    endfunction

    // Shifts one pixel through the line stores and the window, and queues the
    // edge value that falls due on this item, if any.
    function automatic void take_pixel(input logic flush, input logic [7:0] raw);
        logic [PIX_W-1:0] pix;
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] mid;
        int unsigned      slot;
        bit               due;
        bit               at_border;
        int               below;
        int               above;
        int               grad;
        edge_result_t     res;
        pix  = flush ? '0 : raw;
        slot = (in_col < MAX_LINE_PIXELS) ? in_col : 0;
        up   = older_row[slot];
        mid  = newer_row[slot];
        older_row[slot] = mid;
        newer_row[slot] = pix;
        for (int r = 0; r < 3; r++) begin
            window[r][0] = window[r][1];
            window[r][1] = window[r][2];
        end
        window[0][2] = up;
        window[1][2] = mid;
        window[2][2] = pix;

        due = out_started || in_row >= 2 || (in_row == 1 && in_col >= 1);
        if (in_col + 1 >= width_px) begin
            in_col = 0;
            if (in_row < ROW_CAP) begin
                in_row++;
            end
        end else begin
            in_col++;
        end
        if (!due) begin
            return;
        end

        out_started = 1'b1;
        at_border = out_row == 0 || out_row + 1 >= height_rows ||
                    out_col == 0 || out_col + 1 >= width_px;
        if (at_border) begin
            res.edge_value = '0;
        end else begin
            below = int'(window[2][0]) + 2 * int'(window[2][1]) + int'(window[2][2]);
            above = int'(window[0][0]) + 2 * int'(window[0][1]) + int'(window[0][2]);
            grad  = below - above;
            if (grad < 0) begin
                grad = 0;
            end
            if (grad > int'(PIX_MAX)) begin
                grad = int'(PIX_MAX);
            end
            res.edge_value = grad[PIX_W-1:0];
        end
        res.frame_last = (out_row + 1 >= height_rows) && (out_col + 1 >= width_px);

        if (res.frame_last) begin
            restart_frame();
        end else if (out_col + 1 >= width_px) begin
            out_col = 0;
            out_row++;
        end else begin
            out_col++;
        end
        awaited_edges.push_back(res);
    endfunction

    function automatic void check_edge(input logic [7:0] value, input logic last);
        edge_result_t want;
        checked++;
        if (awaited_edges.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_CAP) begin
                $display("%0t ns: unexpected edge item, expected none, got value %0d last %b",
                         $time, value, last);
            end
            return;
        end
        want = awaited_edges.pop_front();
        if (want.edge_value != 0) begin
            nonzero++;
        end
        if (value !== want.edge_value || last !== want.frame_last) begin
            mismatches++;
            if (mismatches <= REPORT_CAP) begin
                $display("%0t ns: edge mismatch, expected value %0d last %b, got value %0d last %b",
                         $time, want.edge_value, want.frame_last, value, last);
            end
        end
    endfunction

    // Results are compared before the input of the same edge is taken in; the
    // block cannot return an item's result on the edge that accepts it.
    always @(posedge aclk) begin
        if (!aresetn) begin
            reset_model();
            awaited_edges.delete();
            pending_edges <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_edge(m_tdata, m_tlast);
            end
            if (cfg_we) begin
                apply_setting(cfg_addr, cfg_wdata);
            end
            if (s_tvalid && s_tready) begin
                take_pixel(s_tuser, s_tdata);
            end
            pending_edges <= awaited_edges.size();
        end
    end

endmodule

// ----- tb/sobel_vertical_edge_3x3_tb.sv -----
// Top of the vertical Sobel edge filter testbench: clock, reset, pixel stimulus,
// register writes, result back-pressure and the verdict. Depends on sve_pkg,
// the filter RTL and sobel_vertical_edge_3x3_checker.
module sobel_vertical_edge_3x3_tb
    import sve_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 11;
    localparam int RANDOM_ITEMS   = 540;
    // Items sent into the one-column, full-height frame before the run ends.
    localparam int TALL_ITEMS     = 48;
    // The block holds an item in stage A and then stage B; pause before a
    // register write, since a trailing item may produce no result.
    localparam int DRAIN_PAUSE    = 8;
    localparam int END_GRACE      = 16;
    // No correct run reaches this limit without a handshake: sender gap, receiver
    // stall, pipeline latency and drain pause together stay below it.
    localparam int WATCHDOG_LIMIT = 1000;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = REG_FRAME_WIDTH;
    logic [DIM_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;   // [7:0] pixel
    logic                  s_tuser   = 1'b0; // [0] cmd: flush item when set
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;          // [7:0] edge_value
    logic                  m_tlast;          // frame_last

    int fail_count;
    int pending_edges;
    int edges_checked;
    int edges_nonzero;

    // When set, neither side inserts gaps, so the block runs at full rate.
    bit calm = 1'b0;
    int items_sent = 0;
    int settings_used = 0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    sobel_vertical_edge_3x3 u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    sobel_vertical_edge_3x3_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .pending_edges (pending_edges),
        .edges_checked (edges_checked),
        .edges_nonzero (edges_nonzero)
    );

    // Result side: after every result taken, the receiver draws a random stall,
    // none when calm is set, during which it holds tready low.
    bit result_taken = 1'b0;
    int stall_left   = 0;

    always @(posedge aclk) begin
        result_taken <= m_tvalid && m_tready;
    end

    always @(negedge aclk) begin
        if (result_taken) begin
            stall_left = calm ? 0 : $urandom_range(0, 4);
        end
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog: a long stretch without any handshake or register write means
    // the block has hung or lost results.
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired after %0d quiet cycles at %0t ns", quiet_cycles, $time);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one item on the input channel, after a random gap, and returns at
    // the falling edge after it has been accepted. Valid stays high from one
    // item to the next when there is no gap.
    task automatic push_pixel(input logic cmd, input logic [7:0] pix);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        repeat (gap) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        @(negedge aclk);
    endtask

    // Stops the input, waits until every expected edge has arrived, then lets
    // the pipeline settle, since trailing items may still be in flight.
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (pending_edges != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_PAUSE) @(negedge aclk);
    endtask

    // Writes the frame width and/or height once the block is idle. Write
    // enable stays high across back-to-back writes.
    task automatic set_frame(input bit write_w, input logic [DIM_W-1:0] w,
                             input bit write_h, input logic [DIM_W-1:0] h);
        settle_block();
        if (write_w) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= REG_FRAME_WIDTH;
            cfg_wdata <= w;
            @(negedge aclk);
        end
        if (write_h) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= REG_FRAME_HEIGHT;
            cfg_wdata <= h;
            @(negedge aclk);
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Pixel values lean towards the extremes so that both clamps are hit often.
    function automatic logic [7:0] pick_pixel();
        int roll;
        roll = $urandom_range(0, 7);
        if (roll == 0) begin
            return 8'h00;
        end else if (roll == 1) begin
            return 8'hFF;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // One well-formed frame: width*height pixels in raster order, now and then
    // a flush item in place of a pixel, then width+1 trailing items that are
    // mostly flush items and sometimes real pixels past the frame end.
    task automatic stream_frame(input int w, input int h);
        for (int i = 0; i < w * h; i++) begin
            push_pixel($urandom_range(0, 15) == 0, pick_pixel());
        end
        for (int i = 0; i <= w; i++) begin
            push_pixel($urandom_range(0, 3) != 0, 8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        int cur_w;
        int cur_h;
        int start_items;
        int w_new;
        int h_new;
        int which;
        int broken_len;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part on a 3x3 frame, whose only interior position is the
        // centre. The first frame has a black top row and a white bottom row,
        // so the gradient saturates high.
        cur_w = 3;
        cur_h = 3;
        set_frame(1'b1, 10'd3, 1'b1, 10'd3);
        for (int i = 0; i < 9; i++) begin
            push_pixel(1'b0, (i < 3) ? 8'h00 : (i < 6) ? 8'($urandom_range(0, 255)) : 8'hFF);
        end
        for (int i = 0; i < 4; i++) begin
            push_pixel(1'b1, 8'($urandom_range(0, 255)));
        end
        // The second frame ends in flush items carrying white pixel data. Such
        // items count as black inside the frame, so the gradient goes negative
        // and clamps to zero. The frame is then drained by real white pixels,
        // which arrive after the frame end and only push the pipeline.
        for (int i = 0; i < 9; i++) begin
            if (i < 3) begin
                push_pixel(1'b0, 8'h40);
            end else if (i < 6) begin
                push_pixel(1'b0, 8'($urandom_range(0, 255)));
            end else begin
                push_pixel(1'b1, 8'hFF);
            end
        end
        for (int i = 0; i < 4; i++) begin
            push_pixel(1'b0, 8'hFF);
        end

        // Random part: small frames, with tiny sizes (one or two pixels, where
        // every result is border) mixed in. Each setting gets one to three
        // frames or, now and then, one frame broken off part way, which the
        // next register write restarts.
        start_items = items_sent;
        while (items_sent - start_items < RANDOM_ITEMS) begin
            calm  = ($urandom_range(0, 3) == 0);
            w_new = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
            h_new = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
            which = $urandom_range(1, 3);
            if (which[0]) begin
                cur_w = w_new;
            end
            if (which[1]) begin
                cur_h = h_new;
            end
            set_frame(which[0], DIM_W'(cur_w), which[1], DIM_W'(cur_h));
            if ($urandom_range(0, 7) == 0) begin
                broken_len = $urandom_range(1, cur_w * cur_h + cur_w);
                for (int i = 0; i < broken_len; i++) begin
                    push_pixel($urandom_range(0, 3) == 0, pick_pixel());
                end
            end else begin
                repeat ($urandom_range(1, 3)) stream_frame(cur_w, cur_h);
            end
        end

        // Register extremes, written out of range: a width of all ones
        // saturates to the full line store and a height of zero becomes one
        // row; then the other way round, one column of full height, of which
        // only the first rows are sent, so no frame end may appear.
        calm = 1'b0;
        set_frame(1'b1, 10'h3FF, 1'b1, 10'h000);
        stream_frame(MAX_LINE_PIXELS, 1);
        set_frame(1'b1, 10'h000, 1'b1, 10'h3FF);
        for (int i = 0; i < TALL_ITEMS; i++) begin
            push_pixel(1'b0, pick_pixel());
        end

        settle_block();
        repeat (END_GRACE) @(posedge aclk);

        $display("Sent %0d items under %0d frame settings, from 1x1 up to 512-pixel lines.",
                 items_sent, settings_used);
        $display("Compared %0d edge items, %0d of them with a non-zero gradient.",
                 edges_checked, edges_nonzero);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- sobel_vertical_edge_3x3.f -----
rtl/sve_pkg.sv
rtl/sve_ram.sv
rtl/sve_ctrl.sv
rtl/sve_window.sv
rtl/sobel_vertical_edge_3x3.sv
rtl/sve_checker.sv
tb/sobel_vertical_edge_3x3_checker.sv
tb/sobel_vertical_edge_3x3_tb.sv
